@@ rtl/core/cpts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types and constants for the credit priority task scheduler.
// ----------------------------------------------------------------------------
package cpts_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int CREDIT_BITS_DEF = 8;

    localparam int OPCODE_W  = 1;
    localparam int TSLOT_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 8;

    localparam logic [CFG_W-1:0] DEF_CREDIT_RST = 8'd15;

    localparam logic [OPCODE_W-1:0] OP_SCHEDULE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_CREATE   = 1'b1;

    typedef enum logic [1:0] {
        ST_DEAD    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2
    } slot_state_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SCHEDULED = 2'd0,
        STAT_CREATED   = 2'd1,
        STAT_REJECTED  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CREATE,
        SEQ_WALK,
        SEQ_UPDATE,
        SEQ_RESULT
    } seq_state_t;

    // write commands from the sequencer to the slot table
    typedef struct packed {
        logic create_en;
        logic sched_en;
        logic refill;
    } table_cmd_t;

endpackage : cpts_pkg
`default_nettype wire

@@ rtl/core/cpts_slot_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_slot_table
// Slot flags, states, credits and ring links with one read port, a ring-flag
// read of the new slot and the create / schedule update writes.
// ----------------------------------------------------------------------------
module cpts_slot_table
    import cpts_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int CREDIT_BITS = CREDIT_BITS_DEF,
    localparam int SLOT_W     = $clog2(NUM_SLOTS)
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  table_cmd_t             cmd,
    input  wire [SLOT_W-1:0]       cur_idx,
    input  wire [SLOT_W-1:0]       new_idx,
    input  wire [SLOT_W-1:0]       pick_idx,
    input  wire [CREDIT_BITS-1:0]  load_credit,
    input  wire [SLOT_W-1:0]       rd_idx,
    output slot_state_t            rd_state,
    output logic [CREDIT_BITS-1:0] rd_credit,
    output logic [SLOT_W-1:0]      rd_succ,
    output logic                   new_in_ring
);

    localparam int CW = (CREDIT_BITS > CFG_W) ? CREDIT_BITS : CFG_W;
    localparam logic [CW-1:0] RST_EXT = CW'(DEF_CREDIT_RST);
    localparam logic [CREDIT_BITS-1:0] CREDIT_RST = RST_EXT[CREDIT_BITS-1:0];

    logic                   in_ring_reg  [NUM_SLOTS];
    logic                   in_ring_next [NUM_SLOTS];
    slot_state_t            state_reg    [NUM_SLOTS];
    slot_state_t            state_next   [NUM_SLOTS];
    logic [CREDIT_BITS-1:0] credit_reg   [NUM_SLOTS];
    logic [CREDIT_BITS-1:0] credit_next  [NUM_SLOTS];
    logic [SLOT_W-1:0]      succ_reg     [NUM_SLOTS];
    logic [SLOT_W-1:0]      succ_next    [NUM_SLOTS];
    logic [CREDIT_BITS-1:0] pick_base;

    assign rd_state    = state_reg[rd_idx];
    assign rd_credit   = credit_reg[rd_idx];
    assign rd_succ     = succ_reg[rd_idx];
    assign new_in_ring = in_ring_reg[new_idx];

    assign pick_base = cmd.refill ? load_credit : credit_reg[pick_idx];

    // create expects rd_idx == cur_idx, so rd_succ is the current slot's link
    always_comb
    begin
        in_ring_next = in_ring_reg;
        state_next   = state_reg;
        credit_next  = credit_reg;
        succ_next    = succ_reg;
        if (cmd.create_en)
        begin
            succ_next[new_idx]    = rd_succ;
            succ_next[cur_idx]    = new_idx;
            in_ring_next[new_idx] = 1'b1;
            credit_next[new_idx]  = load_credit;
            state_next[new_idx]   = ST_READY;
        end
        if (cmd.sched_en)
        begin
            if (cmd.refill)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (in_ring_reg[i])
                    begin
                        credit_next[i] = load_credit;
                    end
                end
            end
            // saturating decrement of the chosen slot
            credit_next[pick_idx] = (pick_base != '0) ? pick_base - 1'b1 : pick_base;
            state_next[cur_idx]   = ST_READY;
            state_next[pick_idx]  = ST_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                in_ring_reg[i] <= (i == 0);
                state_reg[i]   <= (i == 0) ? ST_RUNNING : ST_DEAD;
                credit_reg[i]  <= CREDIT_RST;
                succ_reg[i]    <= '0;
            end
        end
        else
        begin
            in_ring_reg <= in_ring_next;
            state_reg   <= state_next;
            credit_reg  <= credit_next;
            succ_reg    <= succ_next;
        end
    end

endmodule : cpts_slot_table
`default_nettype wire

@@ rtl/core/credit_priority_task_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// credit_priority_task_scheduler
// Ring of task slots; schedule picks the ready slot with the most credit (slot 0
// and a refill if none has any), create links a new slot after the current one.
//
// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_stall    opcode, task_slot
// result    out        out_valid / out_stall  chosen_slot, credits_refilled, status
// config    in         cfg_wr_en              cfg_wr_data (default_credit)
//
// Create: the request passes SEQ_CREATE and SEQ_RESULT before out_valid rises.
// Schedule: SEQ_WALK visits the L slots in the ring (at most NUM_SLOTS), then
// SEQ_UPDATE and SEQ_RESULT; one ring entry per cycle goes through the shared
// credit compare. One request at a time: the next one is taken the cycle after
// the previous one is parked in the output register, even if out_stall holds it
// there. Reset restores slot 0 as running head, credit 15.
// ----------------------------------------------------------------------------
module credit_priority_task_scheduler
    import cpts_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int CREDIT_BITS = CREDIT_BITS_DEF
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire [OPCODE_W-1:0]  opcode,
    input  wire [TSLOT_W-1:0]   task_slot,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [TSLOT_W-1:0]  chosen_slot,
    output logic                credits_refilled,
    output logic [STATUS_W-1:0] status,
    input  wire                 cfg_wr_en,
    input  wire [CFG_W-1:0]     cfg_wr_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int XW     = (SLOT_W > TSLOT_W) ? SLOT_W : TSLOT_W;
    localparam int CW     = (CREDIT_BITS > CFG_W) ? CREDIT_BITS : CFG_W;
    localparam logic [SLOT_W-1:0] LAST_CNT = SLOT_W'(NUM_SLOTS - 1);

    seq_state_t             seq_reg, seq_next;
    logic [OPCODE_W-1:0]    op_reg, op_next;
    logic [TSLOT_W-1:0]     slot_reg, slot_next;
    logic [SLOT_W-1:0]      cur_reg, cur_next;
    logic [SLOT_W-1:0]      node_reg, node_next;
    logic [SLOT_W-1:0]      cnt_reg, cnt_next;
    logic [CREDIT_BITS-1:0] best_reg, best_next;
    logic                   found_reg, found_next;
    logic [SLOT_W-1:0]      pick_reg, pick_next;
    logic [SLOT_W-1:0]      res_chosen_reg, res_chosen_next;
    logic                   res_refill_reg, res_refill_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TSLOT_W-1:0]     out_chosen_reg, out_chosen_next;
    logic                   out_refill_reg, out_refill_next;
    status_t                out_status_reg, out_status_next;
    logic [CFG_W-1:0]       dflt_credit_reg, dflt_credit_next;

    logic                   in_take;
    logic                   out_free;
    logic                   walk_last;
    logic                   better;
    logic                   reject;
    logic [CW-1:0]          dflt_ext;
    logic [CREDIT_BITS-1:0] load_credit;
    logic [XW-1:0]          slot_ext;
    logic [XW-1:0]          chosen_ext;
    logic [SLOT_W-1:0]      new_idx;
    logic [SLOT_W-1:0]      rd_idx;
    table_cmd_t             cmd;
    slot_state_t            rd_state;
    logic [CREDIT_BITS-1:0] rd_credit;
    logic [SLOT_W-1:0]      rd_succ;
    logic                   new_in_ring;

    cpts_slot_table #(
        .NUM_SLOTS   (NUM_SLOTS),
        .CREDIT_BITS (CREDIT_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cur_idx     (cur_reg),
        .new_idx     (new_idx),
        .pick_idx    (pick_reg),
        .load_credit (load_credit),
        .rd_idx      (rd_idx),
        .rd_state    (rd_state),
        .rd_credit   (rd_credit),
        .rd_succ     (rd_succ),
        .new_in_ring (new_in_ring)
    );

    assign dflt_ext    = CW'(dflt_credit_reg);
    assign load_credit = dflt_ext[CREDIT_BITS-1:0];
    assign slot_ext    = XW'(slot_reg);
    assign new_idx     = slot_ext[SLOT_W-1:0];
    assign chosen_ext  = XW'(res_chosen_reg);

    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign walk_last = (rd_succ == '0) || (cnt_reg == LAST_CNT);
    // shared compare: strictly greater keeps the first slot on a tie
    assign better    = (rd_state == ST_READY) && (rd_credit > best_reg);
    assign reject    = (slot_reg == '0) || (int'(slot_reg) >= NUM_SLOTS) || new_in_ring;

    assign out_valid        = out_valid_reg;
    assign chosen_slot      = out_chosen_reg;
    assign credits_refilled = out_refill_reg;
    assign status           = out_status_reg;

    // next state
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_take)
                begin
                    seq_next = (opcode == OP_CREATE) ? SEQ_CREATE : SEQ_WALK;
                end
            end
            SEQ_CREATE: seq_next = SEQ_RESULT;
            SEQ_WALK:
            begin
                if (walk_last)
                begin
                    seq_next = SEQ_UPDATE;
                end
            end
            SEQ_UPDATE: seq_next = SEQ_RESULT;
            SEQ_RESULT:
            begin
                if (out_free)
                begin
                    seq_next = SEQ_IDLE;
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall       = 1'b1;
        rd_idx         = node_reg;
        cmd.create_en  = 1'b0;
        cmd.sched_en   = 1'b0;
        cmd.refill     = 1'b0;
        case (seq_reg)
            SEQ_IDLE:   in_stall = 1'b0;
            SEQ_CREATE:
            begin
                rd_idx        = cur_reg;
                cmd.create_en = !reject;
            end
            SEQ_WALK:   rd_idx = node_reg;
            SEQ_UPDATE:
            begin
                cmd.sched_en = 1'b1;
                cmd.refill   = !found_reg;
            end
            SEQ_RESULT: in_stall = 1'b1;
            default:    in_stall = 1'b1;
        endcase
    end

    // datapath
    always_comb
    begin
        op_next          = op_reg;
        slot_next        = slot_reg;
        cur_next         = cur_reg;
        node_next        = node_reg;
        cnt_next         = cnt_reg;
        best_next        = best_reg;
        found_next       = found_reg;
        pick_next        = pick_reg;
        res_chosen_next  = res_chosen_reg;
        res_refill_next  = res_refill_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        out_chosen_next  = out_chosen_reg;
        out_refill_next  = out_refill_reg;
        out_status_next  = out_status_reg;
        dflt_credit_next = cfg_wr_en ? cfg_wr_data : dflt_credit_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = opcode;
                    slot_next  = task_slot;
                    node_next  = '0;
                    cnt_next   = '0;
                    best_next  = '0;
                    found_next = 1'b0;
                    pick_next  = '0;
                end
            end
            SEQ_CREATE:
            begin
                res_chosen_next = cur_reg;
                res_refill_next = 1'b0;
                res_status_next = reject ? STAT_REJECTED : STAT_CREATED;
            end
            SEQ_WALK:
            begin
                if (better)
                begin
                    best_next  = rd_credit;
                    pick_next  = node_reg;
                    found_next = 1'b1;
                end
                node_next = rd_succ;
                cnt_next  = cnt_reg + 1'b1;
            end
            SEQ_UPDATE:
            begin
                // pick_reg is still slot 0 when nothing was found
                cur_next        = pick_reg;
                res_chosen_next = pick_reg;
                res_refill_next = !found_reg;
                res_status_next = STAT_SCHEDULED;
            end
            SEQ_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_chosen_next = chosen_ext[TSLOT_W-1:0];
                    out_refill_next = res_refill_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= SEQ_IDLE;
            cur_reg         <= '0;
            out_valid_reg   <= 1'b0;
            dflt_credit_reg <= DEF_CREDIT_RST;
        end
        else
        begin
            seq_reg         <= seq_next;
            cur_reg         <= cur_next;
            out_valid_reg   <= out_valid_next;
            dflt_credit_reg <= dflt_credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        node_reg       <= node_next;
        cnt_reg        <= cnt_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        res_chosen_reg <= res_chosen_next;
        res_refill_reg <= res_refill_next;
        res_status_reg <= res_status_next;
        out_chosen_reg <= out_chosen_next;
        out_refill_reg <= out_refill_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTH
    a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> seq_reg != SEQ_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_op_matches_path: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_WALK |-> op_reg == OP_SCHEDULE)
        else $error("ring walk started for a create request");

    a_no_find_no_best: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_UPDATE && !found_reg) |-> (best_reg == '0 && pick_reg == '0))
        else $error("walk ended without a pick but kept a best credit");

    a_refill_picks_head: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && credits_refilled) |-> (chosen_slot == '0 && status == STAT_SCHEDULED))
        else $error("refill result does not choose slot 0");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_RESULT && out_free) |=> out_valid_reg)
        else $error("result not moved into output register");
`endif

endmodule : credit_priority_task_scheduler
`default_nettype wire
